// ----- design/tse_pkg.sv -----
// Shared widths, constants and the pipeline item type for the Taylor sine evaluator.
`timescale 1ns / 1ps

package tse_pkg;

   localparam int ANGLE_W   = 32;
   localparam int MAG_W     = 32;
   localparam int X2_W      = 64;
   localparam int M_W       = 50;
   localparam int S_W       = 54;
   localparam int P_W       = 56;
   localparam int RECIP_W   = 54;
   localparam int DIV_W     = 13;
   localparam int CNT_W     = 5;
   localparam int OUT_W     = 32;
   localparam int FRAC_SH   = 56;
   localparam int M0_SH     = 12;
   localparam int OUT_SH    = 16;
   localparam int SUM_MAG   = 51;

   localparam int M_LO_W    = 25;
   localparam int X2_LO_W   = 32;
   localparam int P_LO_W    = 28;
   localparam int R_LO_W    = 27;
   localparam int PP_W      = (M_W - M_LO_W) + (X2_W - X2_LO_W);
   localparam int MP_W      = M_LO_W + X2_LO_W + PP_W;
   localparam int QP_W      = (P_W - P_LO_W) + (RECIP_W - R_LO_W);
   localparam int QS_W      = P_LO_W + R_LO_W + QP_W;
   localparam int PROD_W    = M_W + DIV_W;

   localparam logic [63:0]      RECIP_NUM      = 64'd1 << FRAC_SH;
   localparam logic [CNT_W-1:0] TERM_COUNT_RST = CNT_W'(10);

   typedef struct packed {
      logic             valid;
      logic             neg;
      logic [CNT_W-1:0] n;
      logic [X2_W-1:0]  x2;
      logic [S_W-1:0]   s;
      logic [M_W-1:0]   m;
   } tse_item_type;

endpackage

// ----- design/tse_front.sv -----
// Front stages: angle magnitude, its square and the leading term.
`timescale 1ns / 1ps

module tse_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            req_tvalid,
   input  logic [tse_pkg::ANGLE_W-1:0]     req_tdata,
   input  logic [tse_pkg::CNT_W-1:0]       n_sel,
   output tse_pkg::tse_item_type           item_o
);
   import tse_pkg::*;

   logic               f1_valid_ff;
   logic               f1_neg_ff;
   logic [MAG_W-1:0]   f1_mag_ff;
   logic [CNT_W-1:0]   f1_n_ff;
   logic [MAG_W-1:0]   f1_mag_in;

   tse_item_type       f2_item_ff;
   tse_item_type       f2_item_in;

   always_comb begin
      f1_mag_in = req_tdata[ANGLE_W-1] ? (MAG_W'(0) - MAG_W'(req_tdata)) : MAG_W'(req_tdata);
   end

   always_comb begin
      f2_item_in.valid = f1_valid_ff;
      f2_item_in.neg   = f1_neg_ff;
      f2_item_in.n     = f1_n_ff;
      f2_item_in.x2    = X2_W'(f1_mag_ff) * X2_W'(f1_mag_ff);
      f2_item_in.s     = '0;
      f2_item_in.m     = M_W'(f1_mag_ff) << M0_SH;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff       <= 1'b0;
         f2_item_ff.valid  <= 1'b0;
      end else if (advance) begin
         f1_valid_ff       <= req_tvalid;
         f2_item_ff.valid  <= f2_item_in.valid;
      end
      if (advance) begin
         f1_neg_ff        <= req_tdata[ANGLE_W-1];
         f1_mag_ff        <= f1_mag_in;
         f1_n_ff          <= n_sel;
         f2_item_ff.neg   <= f2_item_in.neg;
         f2_item_ff.n     <= f2_item_in.n;
         f2_item_ff.x2    <= f2_item_in.x2;
         f2_item_ff.s     <= f2_item_in.s;
         f2_item_ff.m     <= f2_item_in.m;
      end
   end

   assign item_o = f2_item_ff;

endmodule

// ----- design/tse_term.sv -----
// One Taylor term: adds +/- the previous term into the sum; next term = term*x^2/2^56/((2j)(2j+1)), five stages.
`timescale 1ns / 1ps

module tse_term #(
   parameter int TERM_IDX = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  tse_pkg::tse_item_type  item_i,
   output tse_pkg::tse_item_type  item_o
);
   import tse_pkg::*;

   localparam int                 DIV    = (2 * TERM_IDX) * (2 * TERM_IDX + 1);
   localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'(RECIP_NUM / DIV);
   localparam logic [DIV_W-1:0]   DIV_C  = DIV_W'(DIV);
   localparam logic [CNT_W-1:0]   PREV   = CNT_W'(TERM_IDX - 1);

   // stage 1: accumulate previous term, partial products of m * x2
   logic              s1_valid_ff;
   logic              s1_neg_ff;
   logic [CNT_W-1:0]  s1_n_ff;
   logic [X2_W-1:0]   s1_x2_ff;
   logic [S_W-1:0]    s1_s_ff;
   logic [S_W-1:0]    s1_s_in;
   logic [PP_W-1:0]   s1_pp_ll_ff, s1_pp_hl_ff, s1_pp_lh_ff, s1_pp_hh_ff;

   // stage 2: p = (m * x2) >> 56
   logic              s2_valid_ff;
   logic              s2_neg_ff;
   logic [CNT_W-1:0]  s2_n_ff;
   logic [X2_W-1:0]   s2_x2_ff;
   logic [S_W-1:0]    s2_s_ff;
   logic [P_W-1:0]    s2_p_ff;
   logic [MP_W-1:0]   s2_sum_in;

   // stage 3: partial products of p * recip
   logic              s3_valid_ff;
   logic              s3_neg_ff;
   logic [CNT_W-1:0]  s3_n_ff;
   logic [X2_W-1:0]   s3_x2_ff;
   logic [S_W-1:0]    s3_s_ff;
   logic [P_W-1:0]    s3_p_ff;
   logic [QP_W-1:0]   s3_q_ll_ff, s3_q_hl_ff, s3_q_lh_ff, s3_q_hh_ff;

   // stage 4: quotient estimate, low by at most one
   logic              s4_valid_ff;
   logic              s4_neg_ff;
   logic [CNT_W-1:0]  s4_n_ff;
   logic [X2_W-1:0]   s4_x2_ff;
   logic [S_W-1:0]    s4_s_ff;
   logic [P_W-1:0]    s4_p_ff;
   logic [M_W-1:0]    s4_q_ff;
   logic [QS_W-1:0]   s4_qsum_in;

   // stage 5: remainder correction
   tse_item_type      s5_item_ff;
   logic [PROD_W-1:0] s5_prod;
   logic [P_W-1:0]    s5_diff;
   logic [M_W-1:0]    s5_m_in;

   always_comb begin
      s1_s_in = item_i.s;
      if (item_i.n >= PREV) begin
         if (PREV[0]) begin
            s1_s_in = item_i.s - S_W'(item_i.m);
         end else begin
            s1_s_in = item_i.s + S_W'(item_i.m);
         end
      end
   end

   always_comb begin
      s2_sum_in = MP_W'(s1_pp_ll_ff)
                + (MP_W'(s1_pp_hl_ff) << M_LO_W)
                + (MP_W'(s1_pp_lh_ff) << X2_LO_W)
                + (MP_W'(s1_pp_hh_ff) << (M_LO_W + X2_LO_W));
      s4_qsum_in = QS_W'(s3_q_ll_ff)
                 + (QS_W'(s3_q_hl_ff) << P_LO_W)
                 + (QS_W'(s3_q_lh_ff) << R_LO_W)
                 + (QS_W'(s3_q_hh_ff) << (P_LO_W + R_LO_W));
      s5_prod = PROD_W'(s4_q_ff) * PROD_W'(DIV_C);
      s5_diff = s4_p_ff - s5_prod[P_W-1:0];
      s5_m_in = (s5_diff >= P_W'(DIV_C)) ? (s4_q_ff + M_W'(1)) : s4_q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         s3_valid_ff      <= 1'b0;
         s4_valid_ff      <= 1'b0;
         s5_item_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_valid_ff      <= item_i.valid;
         s2_valid_ff      <= s1_valid_ff;
         s3_valid_ff      <= s2_valid_ff;
         s4_valid_ff      <= s3_valid_ff;
         s5_item_ff.valid <= s4_valid_ff;
      end
      if (advance) begin
         s1_neg_ff   <= item_i.neg;
         s1_n_ff     <= item_i.n;
         s1_x2_ff    <= item_i.x2;
         s1_s_ff     <= s1_s_in;
         s1_pp_ll_ff <= PP_W'(item_i.m[M_LO_W-1:0]) * PP_W'(item_i.x2[X2_LO_W-1:0]);
         s1_pp_hl_ff <= PP_W'(item_i.m[M_W-1:M_LO_W]) * PP_W'(item_i.x2[X2_LO_W-1:0]);
         s1_pp_lh_ff <= PP_W'(item_i.m[M_LO_W-1:0]) * PP_W'(item_i.x2[X2_W-1:X2_LO_W]);
         s1_pp_hh_ff <= PP_W'(item_i.m[M_W-1:M_LO_W]) * PP_W'(item_i.x2[X2_W-1:X2_LO_W]);

         s2_neg_ff   <= s1_neg_ff;
         s2_n_ff     <= s1_n_ff;
         s2_x2_ff    <= s1_x2_ff;
         s2_s_ff     <= s1_s_ff;
         s2_p_ff     <= s2_sum_in[FRAC_SH+P_W-1:FRAC_SH];

         s3_neg_ff   <= s2_neg_ff;
         s3_n_ff     <= s2_n_ff;
         s3_x2_ff    <= s2_x2_ff;
         s3_s_ff     <= s2_s_ff;
         s3_p_ff     <= s2_p_ff;
         s3_q_ll_ff  <= QP_W'(s2_p_ff[P_LO_W-1:0]) * QP_W'(RECIP[R_LO_W-1:0]);
         s3_q_hl_ff  <= QP_W'(s2_p_ff[P_W-1:P_LO_W]) * QP_W'(RECIP[R_LO_W-1:0]);
         s3_q_lh_ff  <= QP_W'(s2_p_ff[P_LO_W-1:0]) * QP_W'(RECIP[RECIP_W-1:R_LO_W]);
         s3_q_hh_ff  <= QP_W'(s2_p_ff[P_W-1:P_LO_W]) * QP_W'(RECIP[RECIP_W-1:R_LO_W]);

         s4_neg_ff   <= s3_neg_ff;
         s4_n_ff     <= s3_n_ff;
         s4_x2_ff    <= s3_x2_ff;
         s4_s_ff     <= s3_s_ff;
         s4_p_ff     <= s3_p_ff;
         s4_q_ff     <= s4_qsum_in[FRAC_SH+M_W-1:FRAC_SH];

         s5_item_ff.neg <= s4_neg_ff;
         s5_item_ff.n   <= s4_n_ff;
         s5_item_ff.x2  <= s4_x2_ff;
         s5_item_ff.s   <= s4_s_ff;
         s5_item_ff.m   <= s5_m_in;
      end
   end

   assign item_o = s5_item_ff;

   a_product_fits: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (s2_sum_in[MP_W-1:FRAC_SH+P_W] == '0))
      else $error("term product exceeds quotient width");

   a_estimate_close: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> (s5_diff < P_W'(2 * DIV)))
      else $error("reciprocal estimate off by more than one");

endmodule

// ----- design/tse_back.sv -----
// Back stages: last term, sign, Q8.24 conversion, saturation and output register.
`timescale 1ns / 1ps

module tse_back #(
   parameter int MAX_TERMS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  tse_pkg::tse_item_type         item_i,
   output logic                          rsp_tvalid,
   output logic [tse_pkg::OUT_W-1:0]     rsp_tdata,
   output logic                          rsp_tuser
);
   import tse_pkg::*;

   localparam int                      LW    = CNT_W + 1;
   localparam logic [LW-1:0]           LAST  = LW'(MAX_TERMS);
   localparam int                      Q_W   = S_W - OUT_SH;
   localparam logic signed [Q_W-1:0]   Q_MAX = Q_W'(64'sd2147483647);
   localparam logic signed [Q_W-1:0]   Q_MIN = Q_W'(-64'sd2147483648);

   logic                 b1_valid_ff;
   logic                 b1_neg_ff;
   logic [S_W-1:0]       b1_s_ff;
   logic [S_W-1:0]       b1_s_in;

   logic                 rsp_tvalid_ff;
   logic [OUT_W-1:0]     rsp_tdata_ff;
   logic [OUT_W-1:0]     rsp_tdata_in;
   logic                 rsp_tuser_ff;
   logic                 rsp_tuser_in;
   logic [S_W-1:0]       b2_s;
   logic signed [Q_W-1:0] b2_q;

   always_comb begin
      b1_s_in = item_i.s;
      if ({1'b0, item_i.n} >= LAST) begin
         if (LAST[0]) begin
            b1_s_in = item_i.s - S_W'(item_i.m);
         end else begin
            b1_s_in = item_i.s + S_W'(item_i.m);
         end
      end
   end

   always_comb begin
      b2_s = b1_neg_ff ? (S_W'(0) - b1_s_ff) : b1_s_ff;
      b2_q = $signed(b2_s[S_W-1:OUT_SH]);
      rsp_tuser_in = 1'b1;
      if (b2_q > Q_MAX) begin
         rsp_tdata_in = OUT_W'(Q_MAX);
      end else if (b2_q < Q_MIN) begin
         rsp_tdata_in = OUT_W'(Q_MIN);
      end else begin
         rsp_tdata_in = b2_q[OUT_W-1:0];
         rsp_tuser_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (advance) begin
         b1_valid_ff   <= item_i.valid;
         rsp_tvalid_ff <= b1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b1_neg_ff    <= item_i.neg;
         b1_s_ff      <= b1_s_in;
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      b1_valid_ff |-> (b1_s_ff[S_W-1:SUM_MAG] == '0 || b1_s_ff[S_W-1:SUM_MAG] == '1))
      else $error("Taylor sum outside expected range");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_tuser_ff) |->
         (rsp_tdata_ff == OUT_W'(Q_MAX) || rsp_tdata_ff == OUT_W'(Q_MIN)))
      else $error("saturated result is not a range limit");

endmodule

// ----- design/taylor_sine_evaluator.sv -----
// Each Taylor term is a five-stage multiply/reciprocal unit between front and back stages.
// Throughput: one request per cycle while the output is not stalled.
// The whole pipeline holds while a result waits on rsp_tready.
// Reset (synchronous, active high) clears all valid bits and sets term_count to 10.
// The term count is sampled per request at accept time.
`timescale 1ns / 1ps

module taylor_sine_evaluator #(
   parameter int MAX_TERMS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [tse_pkg::ANGLE_W-1:0]   req_tdata,   // [31:0] angle
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [tse_pkg::OUT_W-1:0]     rsp_tdata,   // [31:0] sine_value
   output logic                          rsp_tuser,   // [0] saturated
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tse_pkg::CNT_W-1:0]     csr_data     // [4:0] term_count
);
   import tse_pkg::*;

   localparam int LW = CNT_W + 1;

   logic [CNT_W-1:0] term_count_ff;
   logic [CNT_W-1:0] n_sel;
   logic             advance;
   tse_item_type     chain [0:MAX_TERMS];

   assign csr_ready  = 1'b1;
   assign advance    = ~rsp_tvalid | rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         term_count_ff <= TERM_COUNT_RST;
      end else if (csr_valid && csr_ready) begin
         term_count_ff <= csr_data;
      end
   end

   always_comb begin
      n_sel = term_count_ff;
      if ({1'b0, term_count_ff} > LW'(MAX_TERMS)) begin
         n_sel = CNT_W'(MAX_TERMS);
      end
   end

   tse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .n_sel      (n_sel),
      .item_o     (chain[0])
   );

   for (genvar g = 1; g <= MAX_TERMS; g++) begin : g_term
      tse_term #(
         .TERM_IDX (g)
      ) u_term (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .item_i  (chain[g-1]),
         .item_o  (chain[g])
      );
   end

   tse_back #(
      .MAX_TERMS (MAX_TERMS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item_i     (chain[MAX_TERMS]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the Taylor sine evaluator: random and directed angles, checked in order.
`timescale 1ns / 1ps

module testbench;
   import tse_pkg::*;

   localparam int      TERM_LIMIT = 16;
   localparam int      IDLE_PCT   = 36;
   localparam longint  SINE_MAX   = 64'sd2147483647;
   localparam longint  SINE_MIN   = -64'sd2147483648;

   typedef struct {
      logic [ANGLE_W-1:0] angle;
      logic [OUT_W-1:0]   sine_value;
      logic               saturated;
   } sine_result_type;

   class sine_scoreboard;
      sine_result_type  expected_q[$];
      logic [CNT_W-1:0] term_count;
      int               mismatches;

      function new();
         term_count = TERM_COUNT_RST;
         mismatches = 0;
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("mismatch at %0t: %s", $realtime, what);
      endtask

      function void write_term_count(logic [CNT_W-1:0] value);
         term_count = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Fixed-point Taylor sum: Q.40 terms, floor to Q8.24, clamp.
      function void note_request(logic [ANGLE_W-1:0] angle);
         sine_result_type exp_res;
         logic         neg;
         logic [32:0]  mag;
         logic [63:0]  x2;
         logic [63:0]  term;
         logic [63:0]  divisor;
         logic [127:0] prod;
         longint       sum;
         longint       q;
         int           n;
         neg  = angle[ANGLE_W-1];
         mag  = neg ? (33'h1_0000_0000 - {1'b0, angle}) : {1'b0, angle};
         x2   = mag * mag;
         term = 64'(mag) << 12;
         sum  = $signed(term);
         n    = (term_count > TERM_LIMIT) ? TERM_LIMIT : int'(term_count);
         for (int j = 1; j <= n; j++) begin
            prod    = {64'b0, term} * {64'b0, x2};
            divisor = 64'((2 * j) * (2 * j + 1));
            term    = 64'(prod >> 56) / divisor;
            if (j % 2 == 1) begin
               sum -= $signed(term);
            end else begin
               sum += $signed(term);
            end
         end
         if (neg) begin
            sum = -sum;
         end
         q = sum >>> 16;
         exp_res.angle     = angle;
         exp_res.saturated = 1'b0;
         if (q > SINE_MAX) begin
            q = SINE_MAX;
            exp_res.saturated = 1'b1;
         end else if (q < SINE_MIN) begin
            q = SINE_MIN;
            exp_res.saturated = 1'b1;
         end
         exp_res.sine_value = q[OUT_W-1:0];
         expected_q.push_back(exp_res);
      endfunction

      task check_result(logic [OUT_W-1:0] value, logic sat);
         sine_result_type exp_res;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h sat %b", value, sat));
            return;
         end
         exp_res = expected_q.pop_front();
         if (value !== exp_res.sine_value) begin
            report_mismatch($sformatf("angle %h: sine_value %h, expected %h",
                                      exp_res.angle, value, exp_res.sine_value));
         end
         if (sat !== exp_res.saturated) begin
            report_mismatch($sformatf("angle %h: saturated %b, expected %b",
                                      exp_res.angle, sat, exp_res.saturated));
         end
      endtask
   endclass

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [ANGLE_W-1:0] req_tdata  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [OUT_W-1:0]   rsp_tdata;
   logic               rsp_tuser;
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   logic [CNT_W-1:0]   csr_data   = '0;
   logic               steady     = 1'b0;

   sine_scoreboard sb = new();

   taylor_sine_evaluator #(
      .MAX_TERMS(TERM_LIMIT)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            sb.write_term_count(csr_data);
         end
         if (req_tvalid && req_tready) begin
            sb.note_request(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata, rsp_tuser);
         end
      end
   end

   task automatic send_angle(input logic [ANGLE_W-1:0] angle);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= angle;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   task automatic write_term_count(input logic [CNT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drain();
      @(posedge clock);
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic logic [ANGLE_W-1:0] random_angle();
      logic [ANGLE_W-1:0] a;
      case ($urandom_range(0, 3))
         0, 1: a = $urandom;
         2: begin
            // within +-pi
            a = $urandom_range(0, 32'h3243F6A9);
            if ($urandom_range(0, 1) == 1) begin
               a = -a;
            end
         end
         default: begin
            // close to +-8
            if ($urandom_range(0, 1) == 1) begin
               a = 32'h7FFF_FFFF - $urandom_range(0, 255);
            end else begin
               a = 32'h8000_0000 + $urandom_range(0, 255);
            end
         end
      endcase
      return a;
   endfunction

   logic [ANGLE_W-1:0] directed_angles[14] = '{
      32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
      32'h8000_0000, 32'h1000_0000, 32'hF000_0000, 32'h1921_FB54,
      32'h3243_F6A9, 32'hCDBC_0957, 32'h4000_0000, 32'hC000_0000,
      32'h5555_5555, 32'hAAAA_AAAA
   };

   logic [CNT_W-1:0] phase_counts[9] = '{
      CNT_W'(0), CNT_W'(1), CNT_W'(2), CNT_W'(3), CNT_W'(16),
      CNT_W'(31), CNT_W'(17), CNT_W'(7), CNT_W'(10)
   };

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_angles[i]) begin
         send_angle(directed_angles[i]);
      end
      req_tvalid <= 1'b0;
      wait_drain();

      foreach (phase_counts[p]) begin
         write_term_count(phase_counts[p]);
         steady <= (phase_counts[p] == CNT_W'(16));
         for (int k = 0; k < 50; k++) begin
            if (phase_counts[p] == CNT_W'(31) && k == 25) begin
               req_tvalid <= 1'b0;
               wait_drain();
            end
            send_angle(random_angle());
         end
         req_tvalid <= 1'b0;
         wait_drain();
         steady <= 1'b0;
      end

      repeat (100) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ----- sim.f -----
design/tse_pkg.sv
design/tse_front.sv
design/tse_term.sv
design/tse_back.sv
design/taylor_sine_evaluator.sv
tb/testbench.sv
